/* rtl/ssrq_pkg.sv */
// ----------------------------------------------------------------------------
// ssrq_pkg
// Shared types and codes for the sector sorted request queue.
// ----------------------------------------------------------------------------
package ssrq_pkg;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam int FIELD_SECTOR_BITS = 48;

  typedef struct packed {
    logic [1:0]                   action;
    logic [FIELD_SECTOR_BITS-1:0] sector;
    logic                         is_write;
    logic [7:0]                   tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic                         out_valid;
    logic [FIELD_SECTOR_BITS-1:0] out_sector;
    logic                         out_is_write;
    logic [7:0]                   out_tag;
    logic [4:0]                   queue_count;
    logic [FIELD_SECTOR_BITS-1:0] head_position;
  } out_item_t;

  // Decoded command handed from the front to the back; an unused action
  // code decodes to no operation at all.
  typedef struct packed {
    logic                         is_insert;
    logic                         is_dispatch;
    logic                         is_remove;
    logic [FIELD_SECTOR_BITS-1:0] sector;
    logic                         is_write;
    logic [7:0]                   tag;
  } cmd_t;

endpackage

/* rtl/ssrq_front.sv */
// ----------------------------------------------------------------------------
// ssrq_front
// Accepts commands, decodes the action and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ssrq_front import ssrq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;
  cmd_t       dec;

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = mem_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_take && cmd_valid;

  always_comb begin
    dec             = '0;
    dec.sector      = in_item.sector;
    dec.is_write    = in_item.is_write;
    dec.tag         = in_item.tag;
    unique case (in_item.action)
      ACT_INSERT:   dec.is_insert   = 1'b1;
      ACT_DISPATCH: dec.is_dispatch = 1'b1;
      ACT_REMOVE:   dec.is_remove   = 1'b1;
      default:      ;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* rtl/ssrq_back.sv */
// ----------------------------------------------------------------------------
// ssrq_back
// Sorted register queue with parallel compare-and-shift, and result queue.
// ----------------------------------------------------------------------------
module ssrq_back import ssrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SECTOR_BITS = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  cmd_t      cmd,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [SECTOR_BITS-1:0] sec_r [QUEUE_DEPTH];
  logic [SECTOR_BITS-1:0] sec_nxt [QUEUE_DEPTH];
  logic                   wr_r [QUEUE_DEPTH];
  logic                   wr_nxt [QUEUE_DEPTH];
  logic [7:0]             tag_r [QUEUE_DEPTH];
  logic [7:0]             tag_nxt [QUEUE_DEPTH];
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SECTOR_BITS-1:0] head_r, head_nxt;

  logic [QUEUE_DEPTH-1:0] ins_sh;
  logic [QUEUE_DEPTH-1:0] after;
  logic [QUEUE_DEPTH-1:0] shift_dn;
  logic                   found;
  logic                   is_full;
  logic                   is_empty;
  logic                   go;
  logic                   do_ins;
  logic                   do_rm;
  logic [63:0]            sec_wide;
  logic [SECTOR_BITS-1:0] sec_in;
  logic [63:0]            head_wide;
  logic [63:0]            out_wide;
  out_item_t              res;

  out_item_t  res_mem_r [2];
  logic       res_wr_r, res_rd_r;
  logic [1:0] res_cnt_r;
  logic       res_full;
  logic       res_pop;

  assign res_full  = (res_cnt_r == 2'd2);
  assign out_empty = (res_cnt_r == 2'd0);
  assign out_item  = res_mem_r[res_rd_r];
  assign res_pop   = out_pop && !out_empty;
  assign go        = cmd_valid && !res_full;
  assign cmd_take  = go;

  assign sec_wide = 64'(cmd.sector);
  assign sec_in   = sec_wide[SECTOR_BITS-1:0];
  assign is_full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign is_empty = (cnt_r == '0);

  // Insert point: first held entry strictly greater; the queue is sorted, so
  // the greater entries form a run up to the fill count.
  // Remove point: first held entry with a matching tag; everything at or
  // past it moves one slot toward the head.
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      ins_sh[k] = ((CW'(k) < cnt_r) && (sec_r[k] > sec_in)) || (CW'(k) == cnt_r);
      acc       = acc | ((CW'(k) < cnt_r) && (tag_r[k] == cmd.tag));
      after[k]  = acc;
      shift_dn[k] = cmd.is_dispatch | after[k];
    end
    found = acc;
  end

  assign do_ins = go && cmd.is_insert && !is_full;
  assign do_rm  = go && ((cmd.is_dispatch && !is_empty) || (cmd.is_remove && found));

  always_comb begin
    int km;
    int kp;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      km = (k > 0) ? k - 1 : 0;
      kp = (k < QUEUE_DEPTH - 1) ? k + 1 : k;
      sec_nxt[k] = sec_r[k];
      wr_nxt[k]  = wr_r[k];
      tag_nxt[k] = tag_r[k];
      if (do_ins) begin
        if (ins_sh[k] && (k > 0) && ins_sh[km]) begin
          sec_nxt[k] = sec_r[km];
          wr_nxt[k]  = wr_r[km];
          tag_nxt[k] = tag_r[km];
        end else if (ins_sh[k]) begin
          sec_nxt[k] = sec_in;
          wr_nxt[k]  = cmd.is_write;
          tag_nxt[k] = cmd.tag;
        end
      end else if (do_rm && shift_dn[k]) begin
        sec_nxt[k] = sec_r[kp];
        wr_nxt[k]  = wr_r[kp];
        tag_nxt[k] = tag_r[kp];
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    if (do_ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rm) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (go && cmd.is_dispatch && !is_empty) begin
      head_nxt = sec_r[0];
    end
  end

  always_comb begin
    logic [31:0] cnt_wide;
    cnt_wide  = 32'(cnt_nxt);
    head_wide = 64'(head_nxt);
    out_wide  = 64'(sec_r[0]);
    res       = '0;
    priority if (cmd.is_insert && is_full) begin
      res.status = ST_FULL;
    end else if (cmd.is_dispatch && is_empty) begin
      res.status = ST_EMPTY;
    end else if (cmd.is_remove && !found) begin
      res.status = ST_NOT_FOUND;
    end else begin
      res.status = ST_OK;
    end
    if (cmd.is_dispatch && !is_empty) begin
      res.out_valid    = 1'b1;
      res.out_sector   = out_wide[FIELD_SECTOR_BITS-1:0];
      res.out_is_write = wr_r[0];
      res.out_tag      = tag_r[0];
    end
    res.queue_count   = cnt_wide[4:0];
    res.head_position = head_wide[FIELD_SECTOR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      head_r    <= '0;
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
      res_wr_r  <= go ? ~res_wr_r : res_wr_r;
      res_rd_r  <= res_pop ? ~res_rd_r : res_rd_r;
      res_cnt_r <= res_cnt_r + 2'(go) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      sec_r[k] <= sec_nxt[k];
      wr_r[k]  <= wr_nxt[k];
      tag_r[k] <= tag_nxt[k];
    end
    if (go) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

endmodule

/* rtl/sector_sorted_request_queue_top.sv */
// Sector sorted request queue. Holds up to QUEUE_DEPTH requests in ascending
// start-sector order (equal sectors first in, first out) and takes insert,
// dispatch-lowest and remove-by-tag commands, one result per command. The
// sorted store is a row of registers updated by a parallel compare-and-shift,
// so one command completes per clock while results are popped: a pushed
// command is registered in the command queue, executed from there, and its
// result is registered in the result queue for popping. Two-entry queues on
// the command and result sides let each side stall without stopping the
// other.
// ----------------------------------------------------------------------------
// sector_sorted_request_queue_top
// Top level: command front end and sorted queue back end.
// ----------------------------------------------------------------------------
module sector_sorted_request_queue_top import ssrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SECTOR_BITS = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  ssrq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  ssrq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
